// ----- rtl/mbti_pkg.sv -----
// Package for the multiply blend of two images: widths, register indexes,
// the enum types of the control logic and the structs passed between modules.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package mbti_pkg;

   localparam int SAMPLE_W    = 17;   // raw input sample, two's complement
   localparam int VALUE_W     = 16;   // clamped sample, maximum and result
   localparam int DIM_REG_W   = 13;   // width and height registers
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int LANES       = 3;    // red, green, blue
   localparam int MAX_DIM_DEF = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_MAX     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_MAX    = 3'd5;

   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_FIRST,
      SEL_SECOND,
      SEL_BLEND
   } sel_type;

   typedef enum logic [1:0] {
      LANE_IDLE,
      LANE_MUL,
      LANE_DIV,
      LANE_DONE
   } lane_state_type;

   typedef enum logic {
      TOP_IDLE,
      TOP_BUSY
   } top_state_type;

   typedef struct packed {
      logic start;
      logic take;
   } lane_ctrl_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] result;
   } lane_stat_type;

   typedef struct packed {
      logic cov_first;
      logic cov_second;
      logic last;
   } pos_type;

endpackage

`default_nettype wire

// ----- rtl/mbti_if.sv -----
// Valid/ready channel interfaces for the pixel-pair requests and the blended
// pixel responses. Depends on mbti_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mbti_req_if import mbti_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] first_red;
   logic signed [SAMPLE_W-1:0] first_green;
   logic signed [SAMPLE_W-1:0] first_blue;
   logic signed [SAMPLE_W-1:0] second_red;
   logic signed [SAMPLE_W-1:0] second_green;
   logic signed [SAMPLE_W-1:0] second_blue;

   modport source (
      output valid, first_red, first_green, first_blue,
             second_red, second_green, second_blue,
      input  ready
   );
   modport sink (
      input  valid, first_red, first_green, first_blue,
             second_red, second_green, second_blue,
      output ready
   );
endinterface

interface mbti_rsp_if import mbti_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] out_red;
   logic [VALUE_W-1:0] out_green;
   logic [VALUE_W-1:0] out_blue;
   logic               frame_last;

   modport source (
      output valid, out_red, out_green, out_blue, frame_last,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, frame_last,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/multiply_blend_two_images.sv -----
// Top level of the multiply blend of two RGB images: configuration registers,
// position counters, three color lanes and the merging output register.
// Depends on mbti_pkg, mbti_if, mbti_pos and mbti_lane.
//
// Usage: the source streams pixel pairs in raster order over the output frame
// on req_bus; each transfer carries the raw red, green and blue samples of
// both images at the current position. The frame is as wide and as high as
// the larger of the two configured image sizes. Each blended pixel leaves on
// rsp_bus, with frame_last set on the final pixel of the frame, after which
// the position counters restart at the top left.
// Sizes and maxima are written through csr_we, csr_index and csr_wdata while
// no pixel is in flight; writes to unused indexes are ignored.
// Timing: a request is taken when the block is idle. Three lanes, one per
// color, register the clamped samples, then their product, then run a
// 16-step radix-2 divider; the merging register loads once all lanes are
// done and it is free, and only then does the block take the next pixel.
// When the receiver stalls, the finished pixel waits in the output register
// while the next request is already accepted and computed; the lanes then
// hold their results until the register is free.
// Reset (synchronous, active high) clears the counters and the channel state
// and restores sizes of 1 by 1 and maxima of 255.
`timescale 1ns / 1ps
`default_nettype none

module multiply_blend_two_images import mbti_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mbti_req_if.sink                   req_bus,
   mbti_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [DIM_REG_W-1:0] first_width_ff, first_height_ff;
   logic [DIM_REG_W-1:0] second_width_ff, second_height_ff;
   logic [VALUE_W-1:0]   first_max_ff, second_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_width_ff   <= DIM_REG_W'(1);
         first_height_ff  <= DIM_REG_W'(1);
         second_width_ff  <= DIM_REG_W'(1);
         second_height_ff <= DIM_REG_W'(1);
         first_max_ff     <= VALUE_W'(255);
         second_max_ff    <= VALUE_W'(255);
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_WIDTH:   first_width_ff   <= csr_wdata[DIM_REG_W-1:0];
            CSR_FIRST_HEIGHT:  first_height_ff  <= csr_wdata[DIM_REG_W-1:0];
            CSR_SECOND_WIDTH:  second_width_ff  <= csr_wdata[DIM_REG_W-1:0];
            CSR_SECOND_HEIGHT: second_height_ff <= csr_wdata[DIM_REG_W-1:0];
            CSR_FIRST_MAX:     first_max_ff     <= csr_wdata[VALUE_W-1:0];
            CSR_SECOND_MAX:    second_max_ff    <= csr_wdata[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   top_state_type      state_ff, state_in;
   logic               accept, load, all_done;
   pos_type            pos;
   sel_type            sel;
   logic [VALUE_W-1:0] divisor;
   lane_ctrl_type      lane_ctrl;
   lane_stat_type      lane_stat [LANES];
   logic signed [SAMPLE_W-1:0] raw_first  [LANES];
   logic signed [SAMPLE_W-1:0] raw_second [LANES];

   // The frame position is sampled at the transfer and the counters advance.
   mbti_pos #(.MAX_DIM(MAX_DIM)) u_pos (
      .clock         (clock),
      .reset         (reset),
      .advance       (accept),
      .first_width   (first_width_ff),
      .first_height  (first_height_ff),
      .second_width  (second_width_ff),
      .second_height (second_height_ff),
      .pos           (pos)
   );

   always_comb begin
      raw_first[0]  = req_bus.first_red;
      raw_first[1]  = req_bus.first_green;
      raw_first[2]  = req_bus.first_blue;
      raw_second[0] = req_bus.second_red;
      raw_second[1] = req_bus.second_green;
      raw_second[2] = req_bus.second_blue;
      divisor       = (first_max_ff > second_max_ff) ? first_max_ff : second_max_ff;
      if (pos.cov_first && pos.cov_second) begin
         sel = SEL_BLEND;
      end else if (pos.cov_first) begin
         sel = SEL_FIRST;
      end else if (pos.cov_second) begin
         sel = SEL_SECOND;
      end else begin
         sel = SEL_NONE;
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      mbti_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .raw_first  (raw_first[i]),
         .raw_second (raw_second[i]),
         .max_first  (first_max_ff),
         .max_second (second_max_ff),
         .divisor    (divisor),
         .sel        (sel),
         .stat       (lane_stat[i])
      );
   end

   // Merging stage: the lanes run in lockstep and load one output register.
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_red_ff, out_green_ff, out_blue_ff;
   logic               out_last_ff, last_ff;

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         all_done = all_done & lane_stat[i].done;
      end

      req_bus.ready = state_ff == TOP_IDLE;
      accept        = req_bus.valid && req_bus.ready;
      load          = (state_ff == TOP_BUSY) && all_done
                      && (!out_valid_ff || rsp_bus.ready);
      lane_ctrl.start = accept;
      lane_ctrl.take  = load;

      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: if (accept) state_in = TOP_BUSY;
         TOP_BUSY: if (load)   state_in = TOP_IDLE;
         default:  state_in = TOP_IDLE;
      endcase

      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= pos.last;
      end
      if (load) begin
         out_red_ff   <= lane_stat[0].result;
         out_green_ff <= lane_stat[1].result;
         out_blue_ff  <= lane_stat[2].result;
         out_last_ff  <= last_ff;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_red    = out_red_ff;
   assign rsp_bus.out_green  = out_green_ff;
   assign rsp_bus.out_blue   = out_blue_ff;
   assign rsp_bus.frame_last = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/mbti_pos.sv -----
// Raster position counters and image coverage for the output frame.
// Depends on mbti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbti_pos import mbti_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [DIM_REG_W-1:0] first_width,
   input  wire logic [DIM_REG_W-1:0] first_height,
   input  wire logic [DIM_REG_W-1:0] second_width,
   input  wire logic [DIM_REG_W-1:0] second_height,
   output pos_type                   pos
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = $clog2(MAX_DIM);

   // A size of zero acts as one, a size above the limit as the limit.
   function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_REG_W-1:0] v);
      logic [32:0] e;
      e = 33'(v);
      if (e == 33'd0) begin
         e = 33'd1;
      end else if (e > 33'(MAX_DIM)) begin
         e = 33'(MAX_DIM);
      end
      return DIM_W'(e);
   endfunction

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] w1, h1, w2, h2, ow, oh, col_x, row_x;
   logic             row_end;

   always_comb begin
      w1      = dim_of(first_width);
      h1      = dim_of(first_height);
      w2      = dim_of(second_width);
      h2      = dim_of(second_height);
      ow      = (w1 > w2) ? w1 : w2;
      oh      = (h1 > h2) ? h1 : h2;
      col_x   = DIM_W'(col_ff);
      row_x   = DIM_W'(row_ff);
      row_end = col_x >= (ow - DIM_W'(1));

      pos.cov_first  = (col_x < w1) && (row_x < h1);
      pos.cov_second = (col_x < w2) && (row_x < h2);
      pos.last       = row_end && (row_x >= (oh - DIM_W'(1)));

      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (row_end) begin
            col_in = '0;
            row_in = pos.last ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mbti_lane.sv -----
// One color lane: clamps both samples, multiplies them and divides the
// product by the larger maximum with a radix-2 restoring divider.
// Depends on mbti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbti_lane import mbti_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lane_ctrl_type              ctrl,
   input  wire logic signed [SAMPLE_W-1:0] raw_first,
   input  wire logic signed [SAMPLE_W-1:0] raw_second,
   input  wire logic [VALUE_W-1:0]         max_first,
   input  wire logic [VALUE_W-1:0]         max_second,
   input  wire logic [VALUE_W-1:0]         divisor,
   input  wire sel_type                    sel,
   output lane_stat_type                   stat
);

   localparam int CNT_W = $clog2(VALUE_W);

   function automatic logic [VALUE_W-1:0] clamp(input logic [SAMPLE_W-1:0] raw,
                                                input logic [VALUE_W-1:0] maxv);
      logic [VALUE_W-1:0] v;
      v = raw[VALUE_W-1:0];
      if (raw[SAMPLE_W-1]) begin
         v = '0;
      end else if (v > maxv) begin
         v = maxv;
      end
      return v;
   endfunction

   lane_state_type       state_ff, state_in;
   logic [VALUE_W-1:0]   a_ff, a_in, b_ff, b_in, div_ff, div_in;
   logic [VALUE_W-1:0]   rem_ff, rem_in, quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   sel_type              sel_ff, sel_in;
   logic [2*VALUE_W-1:0] prod;
   logic [VALUE_W:0]     trial;
   logic                 qbit;

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      div_in   = div_ff;
      sel_in   = sel_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      prod     = a_ff * b_ff;
      trial    = {rem_ff, quo_ff[VALUE_W-1]};
      qbit     = trial >= {1'b0, div_ff};

      case (state_ff)
         LANE_IDLE: begin
            if (ctrl.start) begin
               a_in     = clamp(raw_first, max_first);
               b_in     = clamp(raw_second, max_second);
               div_in   = divisor;
               sel_in   = sel;
               state_in = LANE_MUL;
            end
         end
         LANE_MUL: begin
            // Both factors are at most the divisor, so the high half of the
            // product is already below it and the quotient fits in 16 bits.
            rem_in   = prod[2*VALUE_W-1:VALUE_W];
            quo_in   = prod[VALUE_W-1:0];
            cnt_in   = '0;
            state_in = LANE_DIV;
         end
         LANE_DIV: begin
            rem_in = qbit ? VALUE_W'(trial - {1'b0, div_ff}) : trial[VALUE_W-1:0];
            quo_in = {quo_ff[VALUE_W-2:0], qbit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
               state_in = LANE_DONE;
            end
         end
         LANE_DONE: begin
            if (ctrl.take) begin
               state_in = LANE_IDLE;
            end
         end
         default: state_in = LANE_IDLE;
      endcase

      stat.done = state_ff == LANE_DONE;
      case (sel_ff)
         SEL_BLEND:  stat.result = (div_ff == '0) ? '0 : quo_ff;
         SEL_FIRST:  stat.result = a_ff;
         SEL_SECOND: stat.result = b_ff;
         default:    stat.result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      div_ff <= div_in;
      sel_ff <= sel_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire
